>>> rtl/l4pf_pkg.sv
// Shared types, codes and constants of the L4 port firewall.
package l4pf_pkg;

    localparam int unsigned RULE_SLOTS_DEF  = 256;
    localparam int unsigned IFACE_SLOTS_DEF = 1024;

    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [5:0] OFF_ET_HI    = 6'd12;
    localparam logic [5:0] OFF_ET_LO    = 6'd13;
    localparam logic [5:0] OFF_PROTO    = 6'd23;
    localparam logic [5:0] OFF_PORT_HI  = 6'd36;
    localparam logic [5:0] OFF_PORT_LO  = 6'd37;
    localparam logic [5:0] OFF_CAP      = 6'd55;
    localparam logic [5:0] LEN_ETH      = 6'd14;
    localparam logic [5:0] LEN_IPV4     = 6'd34;
    localparam logic [5:0] LEN_TCP      = 6'd54;
    localparam logic [5:0] LEN_UDP      = 6'd42;

    localparam logic [1:0] CNT_ALLOWED = 2'd0;
    localparam logic [1:0] CNT_BLOCKED = 2'd1;
    localparam logic [1:0] CNT_TCP     = 2'd2;
    localparam logic [1:0] CNT_UDP     = 2'd3;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_RULE  = 2'd1,
        ACT_IFACE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        VC_OFF     = 3'd0,
        VC_SHORT   = 3'd1,
        VC_TRUNC   = 3'd2,
        VC_ALLOWED = 3'd3,
        VC_BLOCKED = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_RUN    = 2'd1,
        ST_SEARCH = 2'd2,
        ST_FINISH = 2'd3
    } t_state;

    // Lookup moving along the rule cells.
    typedef struct packed {
        logic        valid;
        logic [15:0] port;
        logic [7:0]  proto;
        logic        hit;
        logic        blk;
    } t_query;

    // Rule write broadcast to all cells.
    typedef struct packed {
        logic        en;
        logic [7:0]  slot;
        logic        present;
        logic [15:0] port;
        logic [7:0]  proto;
        logic        blk;
    } t_rule_wr;

endpackage

>>> rtl/l4pf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module l4pf_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/l4pf_rule_cell.sv
// One rule slot: holds a rule and checks the lookup passing through it.
module l4pf_rule_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  l4pf_pkg::t_rule_wr i_wr,
    input  l4pf_pkg::t_query   i_q,
    output l4pf_pkg::t_query   o_q
);
    localparam bit REACHABLE = (CELL_IDX < 256);

    logic             r_present;
    logic [15:0]      r_port;
    logic [7:0]       r_proto;
    logic             r_blk;
    l4pf_pkg::t_query r_q;
    l4pf_pkg::t_query n_q;
    logic             w_sel;

    assign w_sel = REACHABLE && i_wr.en && (32'(i_wr.slot) == 32'(CELL_IDX));

    always_comb begin
        n_q = i_q;
        // An earlier cell already decided; only the first match counts.
        if (i_q.valid && !i_q.hit && r_present &&
            r_port == i_q.port && r_proto == i_q.proto) begin
            n_q.hit = 1'b1;
            n_q.blk = r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_q.valid <= 1'b0;
        end else begin
            if (w_sel) begin
                r_present <= i_wr.present;
            end
            r_q.valid <= n_q.valid;
        end
        if (w_sel) begin
            r_port  <= i_wr.port;
            r_proto <= i_wr.proto;
            r_blk   <= i_wr.blk;
        end
        r_q.port  <= n_q.port;
        r_q.proto <= n_q.proto;
        r_q.hit   <= n_q.hit;
        r_q.blk   <= n_q.blk;
    end

    assign o_q = r_q;
endmodule

>>> rtl/l4_port_firewall.sv
// Top level of the L4 port firewall: frame parsing, rule cell chain, counters.
//
// Channel  Direction  tdata fields (low bit up)                     tuser / tlast
// s_axis   in         data_byte, iface, iface_enable, rule_slot,     action / end_of_packet
//                     rule_present, rule_port, rule_proto,
//                     rule_blocks, counter_sel
// m_axis   out        drop, verdict_class, counter_value             result_kind / none
//
// The last byte of a frame starts a lookup through the chain of RULE_SLOTS
// rule cells, one cell per cycle, so after a frame end no transfer is taken on
// s_axis until the verdict has been written to the output register, which
// waits while that register is full. After reset every entry of the interface
// enable memory is cleared before the first input transfer. A full output
// register stalls the input.
module l4_port_firewall #(
    parameter int unsigned RULE_SLOTS  = l4pf_pkg::RULE_SLOTS_DEF,
    parameter int unsigned IFACE_SLOTS = l4pf_pkg::IFACE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], iface[17:8], iface_enable[18], rule_slot[26:19],
    // rule_present[27], rule_port[43:28], rule_proto[51:44], rule_blocks[52],
    // counter_sel[54:53], zero[55]
    input  logic [55:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drop[0], verdict_class[3:1], counter_value[67:4], zero[71:68]
    output logic [71:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser
);
    localparam int unsigned IF_AW = (IFACE_SLOTS > 1) ? $clog2(IFACE_SLOTS) : 1;

    // Input fields.
    logic [7:0]  w_byte;
    logic [9:0]  w_iface;
    logic        w_iface_en;
    logic [1:0]  w_cnt_sel;
    l4pf_pkg::t_action w_act;

    assign w_byte     = s_axis_tdata[7:0];
    assign w_iface    = s_axis_tdata[17:8];
    assign w_iface_en = s_axis_tdata[18];
    assign w_cnt_sel  = s_axis_tdata[54:53];
    assign w_act      = l4pf_pkg::t_action'(s_axis_tuser);

    // Control and state registers.
    l4pf_pkg::t_state r_state, n_state;
    logic [IF_AW-1:0] r_clr, n_clr;
    logic [5:0]       r_off, n_off;
    logic [9:0]       r_pkt_iface, n_pkt_iface;
    logic [15:0]      r_et, n_et;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_dport, n_dport;
    logic [63:0]      r_cnt [4];
    logic [63:0]      n_cnt [4];

    // Captured at the last byte; hit and block are captured when the lookup ends.
    l4pf_pkg::t_verdict r_cls_pre, n_cls_pre;
    logic             r_is_tcp, n_is_tcp;
    logic             r_if_ok, n_if_ok;
    logic [IF_AW-1:0] r_rd_addr, n_rd_addr;
    logic             r_hit, n_hit;
    logic             r_blk, n_blk;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic               r_out_drop, n_out_drop;
    l4pf_pkg::t_verdict r_out_cls, n_out_cls;
    logic [63:0]        r_out_cnt, n_out_cnt;

    // Enable memory port.
    logic             w_we;
    logic [IF_AW-1:0] w_waddr;
    logic             w_wdata;
    logic             w_rd_en;

    // Rule chain.
    l4pf_pkg::t_rule_wr w_rule_wr;
    l4pf_pkg::t_query   w_chain [RULE_SLOTS+1];
    logic               w_launch;
    logic               w_done;

    logic w_accept, w_out_free, w_off_zero;
    logic [5:0] w_len;
    logic [9:0] w_pi;
    l4pf_pkg::t_verdict w_vc;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == l4pf_pkg::ST_RUN) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_rule_wr.en      = w_accept && (w_act == l4pf_pkg::ACT_RULE);
    assign w_rule_wr.slot    = s_axis_tdata[26:19];
    assign w_rule_wr.present = s_axis_tdata[27];
    assign w_rule_wr.port    = s_axis_tdata[43:28];
    assign w_rule_wr.proto   = s_axis_tdata[51:44];
    assign w_rule_wr.blk     = s_axis_tdata[52];

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_off       = r_off;
        n_pkt_iface = r_pkt_iface;
        n_et        = r_et;
        n_proto     = r_proto;
        n_dport     = r_dport;
        n_cnt       = r_cnt;
        n_cls_pre   = r_cls_pre;
        n_is_tcp    = r_is_tcp;
        n_if_ok     = r_if_ok;
        n_rd_addr   = r_rd_addr;
        n_hit       = r_hit;
        n_blk       = r_blk;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_drop  = r_out_drop;
        n_out_cls   = r_out_cls;
        n_out_cnt   = r_out_cnt;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = 1'b0;
        w_launch    = 1'b0;
        w_off_zero  = (r_off == 6'd0);
        w_pi        = w_off_zero ? w_iface : r_pkt_iface;
        w_len       = r_off;
        w_vc        = l4pf_pkg::VC_ALLOWED;

        case (r_state)
            l4pf_pkg::ST_CLEAR: begin
                w_we = 1'b1;
                if (r_clr == IF_AW'(IFACE_SLOTS - 1)) begin
                    n_state = l4pf_pkg::ST_RUN;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            l4pf_pkg::ST_RUN: begin
                if (w_accept) begin
                    case (w_act)
                        l4pf_pkg::ACT_RULE: begin
                        end
                        l4pf_pkg::ACT_IFACE: begin
                            w_we    = (32'(w_iface) < 32'(IFACE_SLOTS));
                            w_waddr = IF_AW'(w_iface);
                            w_wdata = w_iface_en;
                        end
                        l4pf_pkg::ACT_READ: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = 1'b1;
                            n_out_drop  = 1'b0;
                            n_out_cls   = l4pf_pkg::VC_OFF;
                            n_out_cnt   = r_cnt[w_cnt_sel];
                        end
                        default: begin
                            n_pkt_iface = w_pi;
                            case (r_off)
                                l4pf_pkg::OFF_ET_HI:   n_et = {w_byte, r_et[7:0]};
                                l4pf_pkg::OFF_ET_LO:   n_et = {r_et[15:8], w_byte};
                                l4pf_pkg::OFF_PROTO:   n_proto = w_byte;
                                l4pf_pkg::OFF_PORT_HI: n_dport = {w_byte, r_dport[7:0]};
                                l4pf_pkg::OFF_PORT_LO: n_dport = {r_dport[15:8], w_byte};
                                default: begin
                                end
                            endcase
                            if (r_off < l4pf_pkg::OFF_CAP) begin
                                n_off = r_off + 6'd1;
                            end
                            w_len = n_off;
                            if (s_axis_tlast) begin
                                if (w_len < l4pf_pkg::LEN_ETH ||
                                    n_et != l4pf_pkg::ETHTYPE_IPV4 ||
                                    w_len < l4pf_pkg::LEN_IPV4) begin
                                    w_vc = l4pf_pkg::VC_SHORT;
                                end else if (n_proto == l4pf_pkg::PROTO_TCP) begin
                                    if (w_len < l4pf_pkg::LEN_TCP) w_vc = l4pf_pkg::VC_TRUNC;
                                end else if (n_proto == l4pf_pkg::PROTO_UDP) begin
                                    if (w_len < l4pf_pkg::LEN_UDP) w_vc = l4pf_pkg::VC_TRUNC;
                                end else begin
                                    w_vc = l4pf_pkg::VC_TRUNC;
                                end
                                n_cls_pre   = w_vc;
                                n_is_tcp    = (n_proto == l4pf_pkg::PROTO_TCP);
                                n_if_ok     = (32'(w_pi) < 32'(IFACE_SLOTS));
                                n_rd_addr   = IF_AW'(w_pi);
                                w_launch    = 1'b1;
                                n_state     = l4pf_pkg::ST_SEARCH;
                                n_off       = 6'd0;
                                n_pkt_iface = 10'd0;
                                n_et        = 16'd0;
                                n_proto     = 8'd0;
                                n_dport     = 16'd0;
                            end
                        end
                    endcase
                end
            end
            l4pf_pkg::ST_SEARCH: begin
                if (w_done) begin
                    n_hit   = w_chain[RULE_SLOTS].hit;
                    n_blk   = w_chain[RULE_SLOTS].blk;
                    n_state = l4pf_pkg::ST_FINISH;
                end
            end
            l4pf_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    if (!r_if_ok || !w_rd_en) begin
                        w_vc = l4pf_pkg::VC_OFF;
                    end else if (r_cls_pre != l4pf_pkg::VC_ALLOWED) begin
                        w_vc = r_cls_pre;
                    end else begin
                        if (r_is_tcp) begin
                            n_cnt[l4pf_pkg::CNT_TCP] = r_cnt[l4pf_pkg::CNT_TCP] + 64'd1;
                        end else begin
                            n_cnt[l4pf_pkg::CNT_UDP] = r_cnt[l4pf_pkg::CNT_UDP] + 64'd1;
                        end
                        if (r_hit && r_blk) begin
                            w_vc = l4pf_pkg::VC_BLOCKED;
                            n_cnt[l4pf_pkg::CNT_BLOCKED] =
                                r_cnt[l4pf_pkg::CNT_BLOCKED] + 64'd1;
                        end else begin
                            n_cnt[l4pf_pkg::CNT_ALLOWED] =
                                r_cnt[l4pf_pkg::CNT_ALLOWED] + 64'd1;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_drop  = (w_vc == l4pf_pkg::VC_BLOCKED);
                    n_out_cls   = w_vc;
                    n_out_cnt   = 64'd0;
                    n_state     = l4pf_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = l4pf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= l4pf_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_off       <= 6'd0;
            r_pkt_iface <= 10'd0;
            r_et        <= 16'd0;
            r_proto     <= 8'd0;
            r_dport     <= 16'd0;
            r_cnt       <= '{default: 64'd0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_off       <= n_off;
            r_pkt_iface <= n_pkt_iface;
            r_et        <= n_et;
            r_proto     <= n_proto;
            r_dport     <= n_dport;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cls_pre  <= n_cls_pre;
        r_is_tcp   <= n_is_tcp;
        r_if_ok    <= n_if_ok;
        r_rd_addr  <= n_rd_addr;
        r_hit      <= n_hit;
        r_blk      <= n_blk;
        r_out_kind <= n_out_kind;
        r_out_drop <= n_out_drop;
        r_out_cls  <= n_out_cls;
        r_out_cnt  <= n_out_cnt;
    end

    l4pf_ram #(
        .WIDTH (1),
        .DEPTH (IFACE_SLOTS)
    ) u_iface_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_en)
    );

    assign w_chain[0].valid = w_launch;
    assign w_chain[0].port  = n_dport == 16'd0 ? (r_off == l4pf_pkg::OFF_PORT_LO ?
                              {r_dport[15:8], w_byte} : r_dport) : r_dport;
    assign w_chain[0].proto = (r_off == l4pf_pkg::OFF_PROTO) ? w_byte : r_proto;
    assign w_chain[0].hit   = 1'b0;
    assign w_chain[0].blk   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < RULE_SLOTS; gi++) begin : g_cell
            l4pf_rule_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_rule_wr),
                .i_q     (w_chain[gi]),
                .o_q     (w_chain[gi+1])
            );
        end
    endgenerate

    assign w_done = w_chain[RULE_SLOTS].valid;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {4'd0, r_out_cnt, r_out_cls, r_out_drop};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != l4pf_pkg::ST_RUN) |-> !s_axis_tready)
        else $error("input taken while not in run state");

    a_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == l4pf_pkg::ST_SEARCH))
        else $error("lookup finished outside search");

    a_drop_is_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        (m_axis_tdata[3:1] == l4pf_pkg::VC_BLOCKED && !m_axis_tuser))
        else $error("drop without blocked verdict");

    a_launch_to_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |=> (r_state == l4pf_pkg::ST_SEARCH))
        else $error("lookup launched without entering search");
`endif
endmodule
